### rtl/ttbs_pkg.sv
// Shared constants, types and state record for the tap tempo beat scheduler.
`default_nettype none

package ttbs_pkg;

    // Timestamp width and the fixed-point format of the averaging weight.
    localparam int TIME_BITS       = 32;
    localparam int DECAY_FRAC_BITS = 16;
    localparam int DECAY_BITS      = DECAY_FRAC_BITS + 1;

    // Weight of 1.0 and the reset weight (about 0.9).
    localparam logic [DECAY_BITS-1:0] DECAY_ONE   = DECAY_BITS'(1) << DECAY_FRAC_BITS;
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = DECAY_BITS'(58982);

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [DECAY_BITS-1:0] t_decay;

    // Everything the scheduler carries from one tick to the next.
    typedef struct packed {
        t_time last_tap_time;
        logic  last_tap_valid;
        t_time period;
        logic  period_valid;
        t_time next_beat_time;
        logic  beat_armed;
    } t_sched_state;

endpackage

`default_nettype wire

### rtl/tap_tempo_beat_scheduler.sv
// Top level of the tap tempo beat scheduler: item registers, state and decay register.
//
// Usage: each input item is one tick, carrying the current timestamp and a tap
// flag. Every accepted item yields exactly one result item with the beat flag,
// the tempo valid flag and the current period (zero when no tempo is held).
// Input channel: i_valid / o_ready; result channel: o_valid / i_ready.
// The decay weight is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce this. Datapath: an item
// is taken into the input register, evaluated by a single pass of logic (one
// 33x18 multiply for the average) and lands in the result register once that
// register is free or being drained. Throughput: one item per cycle while the
// result is not stalled, set by the state update that runs from the input
// register to the state registers.
// Stall: while a result waits, one more item is held in the input register;
// o_ready drops only when both are full.
// Reset (synchronous, active low): both registers empty, no tap seen, no
// tempo, no beat scheduled, decay back to about 0.9.
`default_nettype none

module tap_tempo_beat_scheduler
    import ttbs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [DECAY_BITS-1:0] i_cfg_wdata,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [TIME_BITS-1:0] i_now_time,
    input  wire              i_tap,
    output logic             o_valid,
    input  wire              i_ready,
    output logic             o_beat,
    output logic             o_tempo_valid,
    output logic [TIME_BITS-1:0] o_tempo_period
);

    logic         r_in_valid;
    t_time        r_now;
    logic         r_tap;
    logic         r_out_valid;
    logic         r_beat;
    logic         r_tempo_valid;
    t_time        r_tempo_period;
    t_decay       r_decay;
    t_sched_state r_state;
    t_sched_state n_state;
    logic         n_beat;
    logic         w_advance;

    // The held item moves on when the result register is free or being drained.
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    ttbs_core u_core (
        .i_now   (r_now),
        .i_tap   (r_tap),
        .i_decay (r_decay),
        .i_state (r_state),
        .o_state (n_state),
        .o_beat  (n_beat)
    );

    // Control state, scheduler state and the decay register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_decay     <= DECAY_RESET;
            r_state     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_decay <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_now <= i_now_time;
            r_tap <= i_tap;
        end
        if (w_advance) begin
            r_beat         <= n_beat;
            r_tempo_valid  <= n_state.period_valid;
            r_tempo_period <= n_state.period_valid ? n_state.period : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_beat         = r_beat;
    assign o_tempo_valid  = r_tempo_valid;
    assign o_tempo_period = r_tempo_period;

endmodule

`default_nettype wire

### rtl/ttbs_core.sv
// Next-state logic for one tick: tap handling, period averaging and beat scheduling.
`default_nettype none

module ttbs_core
    import ttbs_pkg::*;
(
    input  wire t_time        i_now,
    input  wire               i_tap,
    input  wire t_decay       i_decay,
    input  wire t_sched_state i_state,
    output t_sched_state      o_state,
    output logic              o_beat
);

    localparam int DELTA_W = TIME_BITS + 1;
    localparam int PROD_W  = DELTA_W + DECAY_BITS + 1;
    localparam int ACC_W   = PROD_W + 1;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (DECAY_FRAC_BITS - 1);

    t_time                     w_diff;
    logic                      w_negative;
    logic                      w_in_window;
    t_decay                    w_weight;
    t_time                     w_interval;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [DECAY_BITS:0] w_weight_s;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_base;
    logic signed [ACC_W-1:0]   w_acc;
    t_time                     w_new_period;
    t_sched_state              w_tap_state;
    logic                      w_due;

    // Tap interval as a wrap-safe signed difference.
    assign w_diff      = i_now - i_state.last_tap_time;
    assign w_negative  = w_diff[TIME_BITS-1];
    assign w_in_window = w_negative || ({1'b0, w_diff} < {i_state.period, 1'b0});

    // Blend: period + w * (interval - period), rounded half up.
    assign w_weight   = (i_decay > DECAY_ONE) ? DECAY_ONE : i_decay;
    assign w_interval = w_negative ? '0 : w_diff;
    assign w_delta    = $signed({1'b0, w_interval}) - $signed({1'b0, i_state.period});
    assign w_weight_s = $signed({1'b0, w_weight});
    assign w_prod     = w_delta * w_weight_s;
    assign w_base     = $signed(ACC_W'({i_state.period, {DECAY_FRAC_BITS{1'b0}}}));
    assign w_acc      = w_base + ACC_W'(w_prod) + HALF;
    assign w_new_period = w_acc[DECAY_FRAC_BITS +: TIME_BITS];

    // State after the tap has been taken into account.
    always_comb begin
        w_tap_state = i_state;
        if (i_tap) begin
            if (!i_state.last_tap_valid) begin
                w_tap_state.next_beat_time = i_now;
                w_tap_state.beat_armed     = 1'b1;
            end else if (!i_state.period_valid) begin
                w_tap_state.period         = w_diff;
                w_tap_state.period_valid   = 1'b1;
                w_tap_state.next_beat_time = i_now;
                w_tap_state.beat_armed     = 1'b1;
            end else if (w_in_window) begin
                w_tap_state.next_beat_time = i_state.next_beat_time + w_new_period
                                             - i_state.period;
                w_tap_state.period         = w_new_period;
            end else begin
                w_tap_state.period         = '0;
                w_tap_state.period_valid   = 1'b0;
                w_tap_state.next_beat_time = i_now;
                w_tap_state.beat_armed     = 1'b1;
            end
            w_tap_state.last_tap_time  = i_now;
            w_tap_state.last_tap_valid = 1'b1;
        end
    end

    // A beat fires when the schedule is armed and its time has come.
    assign w_due = ~(i_now - w_tap_state.next_beat_time) >> (TIME_BITS - 1) == t_time'(1);

    always_comb begin
        o_state = w_tap_state;
        o_beat  = 1'b0;
        if (w_tap_state.beat_armed && w_due) begin
            o_beat = 1'b1;
            if (w_tap_state.period_valid) begin
                o_state.next_beat_time = w_tap_state.next_beat_time + w_tap_state.period;
            end else begin
                o_state.beat_armed = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ttbs_checker.sv
// Port-level assertions for the tap tempo beat scheduler and their binding.
`default_nettype none

module ttbs_checker
    import ttbs_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_ready,
    input wire                 o_valid,
    input wire                 i_ready,
    input wire                 o_beat,
    input wire                 o_tempo_valid,
    input wire [TIME_BITS-1:0] o_tempo_period
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Without a tempo the reported period is zero.
    a_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tempo_valid) |-> (o_tempo_period == '0))
        else $error("period reported without a tempo");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_beat) && $stable(o_tempo_valid)
                                   && $stable(o_tempo_period)))
        else $error("stalled result changed");

    // An item taken while the result stalls fills the block, so it accepts only
    // while the result drains.
    a_fill_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && i_valid && o_ready) |=> (o_ready == i_ready))
        else $error("accepting with both registers full");

    // With the result drained and nothing held, the block must accept.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && o_ready && !i_valid) |=> o_ready)
        else $error("empty block not ready");

endmodule

bind tap_tempo_beat_scheduler ttbs_checker u_ttbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_beat         (o_beat),
    .o_tempo_valid  (o_tempo_valid),
    .o_tempo_period (o_tempo_period)
);

`default_nettype wire
